>>> hdl/assert_macros.svh
// Assertion macros for the ordered list RTL.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define OLID_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ordered list assertion failed");

// Next-cycle implication, disabled while reset is active.
`define OLID_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ordered list assertion failed");

`endif

>>> hdl/olid_pkg.sv
// Shared types and codes for the ordered list block.
// Used by olid_cell, olid_ctrl and ordered_list_insert_delete_top.
package olid_pkg;

  // Width of the index that is broadcast to the cells; covers a count of 64.
  localparam int unsigned MarkW = 7;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_SHOW   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] item_value;
    logic [3:0]         position;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    status_e            status;
    logic               last;
  } out_beat_t;

  // What every cell does to its stored value at the clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e       kind;
    logic [MarkW-1:0] mark;
  } cell_ctl_t;

endpackage

>>> hdl/olid_cell.sv
// One storage cell of the ordered list chain.
// Depends on olid_pkg for the broadcast cell command.
module olid_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk_i,
  input  olid_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0]  new_value_i,
  input  logic signed [31:0]  left_i,
  input  logic signed [31:0]  right_i,
  input  logic signed [31:0]  head_i,
  output logic signed [31:0]  value_o
);

  localparam logic [olid_pkg::MarkW-1:0] MyIdx = olid_pkg::MarkW'(CELL_IDX);

  logic signed [31:0] value_q, value_d;

  // Cells compare their place to the mark, but insert shifts all.
  always_comb begin
    value_d = value_q;
    unique case (ctl_i.kind)
      olid_pkg::CELL_HOLD: value_d = value_q;
      olid_pkg::CELL_APPEND: begin
        if (MyIdx == ctl_i.mark) value_d = new_value_i;
      end
      olid_pkg::CELL_INSERT: value_d = left_i;
      olid_pkg::CELL_DELETE: begin
        if (MyIdx >= ctl_i.mark) value_d = right_i;
      end
      olid_pkg::CELL_ROTATE: value_d = (MyIdx == ctl_i.mark) ? head_i : right_i;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> hdl/olid_ctrl.sv
// Controller of the ordered list: element count, show walk and output register.
// Depends on olid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olid_ctrl #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  olid_pkg::in_beat_t  in_beat_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output olid_pkg::out_beat_t out_beat_o,
  input  logic                out_stall_i,
  input  logic signed [31:0]  head_value_i,
  input  logic signed [31:0]  picked_value_i,
  output olid_pkg::cell_ctl_t cell_ctl_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MarkW = olid_pkg::MarkW;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     remain_q, remain_d;
  logic                out_valid_q, out_valid_d;
  olid_pkg::out_beat_t out_beat_q, out_beat_d;

  logic             slot_free;
  logic             in_accept;
  logic [MarkW-1:0] pos_ext;
  logic [MarkW-1:0] count_ext;
  logic [MarkW-1:0] tail_mark;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pos_ext    = MarkW'(in_beat_i.position);
  assign count_ext  = MarkW'(count_q);
  assign tail_mark  = count_ext - MarkW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_beat_d  = out_beat_q;
    cell_ctl_o  = '{kind: olid_pkg::CELL_HOLD, mark: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_d = 1'b1;
          out_beat_d  = '{out_value: '0, status: olid_pkg::STATUS_OK, last: 1'b1};
          unique case (in_beat_i.func)
            olid_pkg::FUNC_APPEND, olid_pkg::FUNC_INSERT: begin
              if (count_q == CntW'(LIST_DEPTH)) begin
                out_beat_d.status = olid_pkg::STATUS_FULL;
              end else begin
                cell_ctl_o.kind = (in_beat_i.func == olid_pkg::FUNC_APPEND) ?
                                  olid_pkg::CELL_APPEND : olid_pkg::CELL_INSERT;
                cell_ctl_o.mark = count_ext;
                count_d         = count_q + CntW'(1);
              end
            end
            olid_pkg::FUNC_DELETE: begin
              if (count_q == '0) begin
                out_beat_d.status = olid_pkg::STATUS_EMPTY;
              end else if (pos_ext >= count_ext) begin
                out_beat_d.status = olid_pkg::STATUS_BADPOS;
              end else begin
                cell_ctl_o           = '{kind: olid_pkg::CELL_DELETE, mark: pos_ext};
                out_beat_d.out_value = picked_value_i;
                count_d              = count_q - CntW'(1);
              end
            end
            olid_pkg::FUNC_SHOW: begin
              if (count_q == '0) begin
                out_beat_d.status = olid_pkg::STATUS_EMPTY;
              end else begin
                // The head goes out now; the window rotates by one.
                cell_ctl_o           = '{kind: olid_pkg::CELL_ROTATE, mark: tail_mark};
                out_beat_d.out_value = head_value_i;
                out_beat_d.last      = (count_q == CntW'(1));
                remain_d             = count_q - CntW'(1);
                if (count_q != CntW'(1)) state_d = ST_SHOW;
              end
            end
            default: out_beat_d.status = olid_pkg::STATUS_OK;
          endcase
        end
      end
      ST_SHOW: begin
        if (slot_free) begin
          cell_ctl_o  = '{kind: olid_pkg::CELL_ROTATE, mark: tail_mark};
          out_valid_d = 1'b1;
          out_beat_d  = '{out_value: head_value_i, status: olid_pkg::STATUS_OK,
                          last: (remain_q == CntW'(1))};
          remain_d    = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      out_beat_q  <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `OLID_ASSERT_NEXT(a_grow_by_one, clk_i, rst_ni,
    in_accept && (cell_ctl_o.kind == olid_pkg::CELL_APPEND ||
                  cell_ctl_o.kind == olid_pkg::CELL_INSERT),
    count_q == $past(count_q) + CntW'(1))
  `OLID_ASSERT_IMPLY(a_show_remain, clk_i, rst_ni,
    state_q == ST_SHOW, remain_q != '0 && remain_q < count_q)
  `OLID_ASSERT_IMPLY(a_not_last_in_show, clk_i, rst_ni,
    out_valid_q && !out_beat_q.last, state_q == ST_SHOW)
  `OLID_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni,
    1'b1, count_q <= CntW'(LIST_DEPTH))

endmodule

>>> hdl/ordered_list_insert_delete_top.sv
// Top level of the ordered list block: a chain of value cells and its controller.
// Depends on olid_pkg, olid_cell and olid_ctrl.
//
//   channel | direction | handshake               | beat type
//   --------+-----------+-------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o | olid_pkg::in_beat_t
//   out     | output    | out_valid_o/out_stall_i | olid_pkg::out_beat_t
//
// Append, insert, delete and every empty, full or bad-position case give one
// beat; insert shifts all cells, delete shifts the cells from the position on
// and append writes one cell. The controller sends the head cell out once per
// stored element on show and rotates the window by one cell per cycle while the output is free.
// Reset clears the element count and the controller; cell contents are not reset.
// A stalled output beat holds in the output register and stops the show walk;
// a new input beat is taken only when the walk is done and the register frees.
module ordered_list_insert_delete_top #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  olid_pkg::in_beat_t  in_beat_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output olid_pkg::out_beat_t out_beat_o,
  input  logic                out_stall_i
);

  localparam int unsigned IdxW  = $clog2(LIST_DEPTH);
  localparam int unsigned MarkW = olid_pkg::MarkW;

  olid_pkg::cell_ctl_t cell_ctl;
  logic signed [31:0]  cell_value [LIST_DEPTH];
  logic signed [31:0]  picked_value;
  logic [MarkW-1:0]    pos_ext;
  logic [IdxW-1:0]     pos_idx;

  // Value under the delete position. Only used when the position is below
  // the count, so an index past the last cell is never selected.
  assign pos_ext      = MarkW'(in_beat_i.position);
  assign pos_idx      = pos_ext[IdxW-1:0];
  assign picked_value = cell_value[pos_idx];

  olid_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_beat_i      (in_beat_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_beat_o     (out_beat_o),
    .out_stall_i    (out_stall_i),
    .head_value_i   (cell_value[0]),
    .picked_value_i (picked_value),
    .cell_ctl_o     (cell_ctl)
  );

  // Cell i holds element i. The left neighbor of the first cell is the new
  // value, and the last cell takes its own value as its right neighbor.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = in_beat_i.item_value;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_final
      assign right_value = cell_value[i];
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
    end

    olid_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .new_value_i (in_beat_i.item_value),
      .left_i      (left_value),
      .right_i     (right_value),
      .head_i      (cell_value[0]),
      .value_o     (cell_value[i])
    );
  end

endmodule
